@@ hdl/wfr_pkg.sv @@
// Shared types and constants for the WebSocket frame receiver.
package wfr_pkg;

  // Reset value of the message size limit
  localparam logic [15:0] MaxBytesReset = 16'd32768;

  // Default depth of the queue between parser and unmasker
  localparam int unsigned QueueDepthDefault = 4;

  // Error codes
  localparam logic [1:0] ErrUnmasked = 2'd0;
  localparam logic [1:0] ErrLen64    = 2'd1;
  localparam logic [1:0] ErrTooLong  = 2'd2;

  // Continuation opcode and the seven-bit length codes for extended lengths
  localparam logic [3:0] OpcodeCont = 4'h0;
  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;

  // One result word as it leaves the parser, still masked
  typedef struct packed {
    logic       has_byte;
    logic [7:0] raw_byte;
    logic [7:0] mask_byte;
    logic       message_end;
    logic       abandoned;
    logic [3:0] message_opcode;
    logic       failed;
    logic [1:0] error_code;
  } cmd_t;

endpackage

@@ hdl/wfr_front.sv @@
// Frame header parser: tracks the frame phase and classifies each input byte.
module wfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          cmd_valid_o,
  output wfr_pkg::cmd_t cmd_o
);
  import wfr_pkg::*;

  localparam logic [2:0] PhHdr0   = 3'd0;
  localparam logic [2:0] PhHdr1   = 3'd1;
  localparam logic [2:0] PhLenHi  = 3'd2;
  localparam logic [2:0] PhLenLo  = 3'd3;
  localparam logic [2:0] PhMask   = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;
  localparam logic [2:0] PhFailed = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] msg_len_q, msg_len_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        open_q, open_d;
  logic [15:0] max_bytes_q;

  logic        fin;
  logic [6:0]  len0;
  logic [3:0]  hdr_op;
  logic [1:0]  idx_inc;
  logic [15:0] left_dec;
  logic [16:0] total_len;
  logic [7:0]  lane;

  assign fin       = flags_q[7];
  assign len0      = byte_i[6:0];
  assign hdr_op    = flags_q[3:0];
  assign idx_inc   = idx_q + 2'd1;
  assign left_dec  = left_q - 16'd1;
  assign total_len = {1'b0, msg_len_q} + {1'b0, left_q};

  // Pick the mask key byte for the current payload position
  always_comb begin
    unique case (idx_q)
      2'd0:    lane = key_q[31:24];
      2'd1:    lane = key_q[23:16];
      2'd2:    lane = key_q[15:8];
      default: lane = key_q[7:0];
    endcase
  end

  // Advance the parser on each accepted byte
  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    left_d      = left_q;
    key_d       = key_q;
    idx_d       = idx_q;
    msg_len_d   = msg_len_q;
    opcode_d    = opcode_q;
    open_d      = open_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.raw_byte       = byte_i;
    cmd_o.mask_byte      = lane;
    cmd_o.message_opcode = opcode_q;
    if (byte_valid_i) begin
      unique case (phase_q)
        PhHdr0: begin
          flags_d = byte_i;
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          if (!byte_i[7]) begin
            cmd_valid_o      = 1'b1;
            cmd_o.failed     = 1'b1;
            cmd_o.error_code = ErrUnmasked;
            phase_d          = PhFailed;
          end else if (len0 == LenCode64) begin
            cmd_valid_o      = 1'b1;
            cmd_o.failed     = 1'b1;
            cmd_o.error_code = ErrLen64;
            phase_d          = PhFailed;
          end else begin
            if (len0 < LenCode16) begin
              left_d  = {9'd0, len0};
              idx_d   = 2'd0;
              phase_d = PhMask;
            end else begin
              phase_d = PhLenHi;
            end
            // A new non-continuation frame drops any open message
            if (hdr_op != OpcodeCont) begin
              if (open_q) begin
                cmd_valid_o     = 1'b1;
                cmd_o.abandoned = 1'b1;
              end
              opcode_d  = hdr_op;
              msg_len_d = 16'd0;
            end
            open_d = 1'b1;
          end
        end
        PhLenHi: begin
          left_d  = {byte_i, 8'd0};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          left_d  = {left_q[15:8], byte_i};
          idx_d   = 2'd0;
          phase_d = PhMask;
        end
        PhMask: begin
          key_d = {key_q[23:0], byte_i};
          idx_d = idx_inc;
          if (idx_inc == 2'd0) begin
            if (left_q == 16'd0) begin
              phase_d = PhHdr0;
              if (fin) begin
                cmd_valid_o       = 1'b1;
                cmd_o.message_end = 1'b1;
                open_d            = 1'b0;
                msg_len_d         = 16'd0;
              end
            end else if (total_len > {1'b0, max_bytes_q}) begin
              cmd_valid_o      = 1'b1;
              cmd_o.failed     = 1'b1;
              cmd_o.error_code = ErrTooLong;
              phase_d          = PhFailed;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          idx_d          = idx_inc;
          left_d         = left_dec;
          msg_len_d      = msg_len_q + 16'd1;
          cmd_valid_o    = 1'b1;
          cmd_o.has_byte = 1'b1;
          if (left_dec == 16'd0) begin
            phase_d = PhHdr0;
            if (fin) begin
              cmd_o.message_end = 1'b1;
              open_d            = 1'b0;
              msg_len_d         = 16'd0;
            end
          end
        end
        default: begin
          // Failed: drop every byte until reset
        end
      endcase
    end
  end

  // Hold parser state and the size limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      flags_q     <= 8'd0;
      left_q      <= 16'd0;
      key_q       <= 32'd0;
      idx_q       <= 2'd0;
      msg_len_q   <= 16'd0;
      opcode_q    <= 4'd0;
      open_q      <= 1'b0;
      max_bytes_q <= MaxBytesReset;
    end else begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      left_q    <= left_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      msg_len_q <= msg_len_d;
      opcode_q  <= opcode_d;
      open_q    <= open_d;
      if (cfg_we_i) begin
        max_bytes_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hdl/wfr_queue.sv @@
// Short register queue that decouples the parser from the unmasker.
module wfr_queue #(
  parameter int unsigned Depth = wfr_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wfr_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          nempty_o,
  input  logic          pop_i,
  output wfr_pkg::cmd_t data_o
);
  import wfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign nempty_o = (count_q != '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;
  assign data_o   = mem_q[rd_ptr_q];

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

@@ hdl/wfr_back.sv @@
// Unmasker and output register that presents results as a queue head.
module wfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_avail_i,
  input  wfr_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic          has_byte_o,
  output logic [7:0]    payload_byte_o,
  output logic          message_end_o,
  output logic          abandoned_o,
  output logic [3:0]    message_opcode_o,
  output logic          failed_o,
  output logic [1:0]    error_code_o
);
  import wfr_pkg::*;

  logic       valid_q;
  logic       has_q, end_q, aband_q, fail_q;
  logic [7:0] byte_q;
  logic [3:0] op_q;
  logic [1:0] code_q;

  // Refill the output register when it is free or being taken
  assign cmd_take_o = cmd_avail_i && (!valid_q || pop_i);
  assign empty_o    = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Unmask payload and hold the result word
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      has_q  <= cmd_i.has_byte;
      byte_q <= cmd_i.has_byte ? (cmd_i.raw_byte ^ cmd_i.mask_byte) : 8'd0;
      end_q  <= cmd_i.message_end;
      aband_q <= cmd_i.abandoned;
      op_q   <= cmd_i.message_opcode;
      fail_q <= cmd_i.failed;
      code_q <= cmd_i.error_code;
    end
  end

  assign has_byte_o       = has_q;
  assign payload_byte_o   = byte_q;
  assign message_end_o    = end_q;
  assign abandoned_o      = aband_q;
  assign message_opcode_o = op_q;
  assign failed_o         = fail_q;
  assign error_code_o     = code_q;

endmodule

@@ hdl/websocket_frame_receiver_core.sv @@
// WebSocket frame receiver: parses, unmasks and reports client frames.
// Throughput: one stream byte per cycle while the word queue is not full.
// A result goes from the parser into the word queue, then into the unmasker's
// output register, where it waits until popped.
// Reset: asynchronous, active low; parser expects a first header byte,
// queue and output are empty, and the message limit returns to 32768.
module websocket_frame_receiver_core #(
  parameter int unsigned QueueDepth = wfr_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        has_byte_o,
  output logic [7:0]  payload_byte_o,
  output logic        message_end_o,
  output logic        abandoned_o,
  output logic [3:0]  message_opcode_o,
  output logic        failed_o,
  output logic [1:0]  error_code_o
);
  import wfr_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd_in, cmd_head;
  logic q_nempty, q_take;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Parse and classify each accepted byte
  wfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (accept),
    .byte_i       (stream_byte_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd_in)
  );

  // Buffer words between parser and unmasker
  wfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_valid),
    .data_i   (cmd_in),
    .full_o   (full),
    .nempty_o (q_nempty),
    .pop_i    (q_take),
    .data_o   (cmd_head)
  );

  // Unmask and present results
  wfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_avail_i      (q_nempty),
    .cmd_i            (cmd_head),
    .cmd_take_o       (q_take),
    .empty_o          (empty),
    .pop_i            (pop),
    .has_byte_o       (has_byte_o),
    .payload_byte_o   (payload_byte_o),
    .message_end_o    (message_end_o),
    .abandoned_o      (abandoned_o),
    .message_opcode_o (message_opcode_o),
    .failed_o         (failed_o),
    .error_code_o     (error_code_o)
  );

endmodule
